// ===== rtl/core/two_class_sequenced_fifo_router_top_defines.svh =====
// Assertion macros shared by the router RTL files.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef TWO_CLASS_SEQUENCED_FIFO_ROUTER_TOP_DEFINES_SVH
`define TWO_CLASS_SEQUENCED_FIFO_ROUTER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TCSFR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define TCSFR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/tcsfr_pkg.sv =====
// Shared types and constants of the two-class FIFO router.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package tcsfr_pkg;

    localparam int DEPTH_A_DEF  = 16;
    localparam int DEPTH_B_DEF  = 16;
    localparam int SEQ_BITS_DEF = 16;

    localparam int PART_W    = 8;
    localparam int OUT_SEQ_W = 16;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_LOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_HIGH = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] A_LOW_RST  = 8'd1;
    localparam logic [CFG_W-1:0] A_HIGH_RST = 8'd12;
    localparam logic [CFG_W-1:0] B_LOW_RST  = 8'd13;
    localparam logic [CFG_W-1:0] B_HIGH_RST = 8'd25;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_END   = 2'd1,
        OP_GET_A = 2'd2,
        OP_GET_B = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DROP  = 3'd1,
        ST_FULL  = 3'd2,
        ST_EMPTY = 3'd3
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic    push_a;
        logic    push_b;
        logic    mark_end;
        logic    adv_seq;
        logic    rd_a;
        logic    rd_b;
        logic    load_now;
        logic    load_pop;
        logic    give_seq;
        logic    sel;
        status_t status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic match_a;
        logic match_b;
        logic full_a;
        logic full_b;
        logic empty_a;
        logic empty_b;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcsfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tcsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tcsfr_ctrl.sv =====
// Controller of the router: decodes each item and sequences a pop through the RAM.
// Depends on tcsfr_pkg and the assertion header.
`default_nettype none
`include "two_class_sequenced_fifo_router_top_defines.svh"

module tcsfr_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire tcsfr_pkg::op_t        op,
    input  wire tcsfr_pkg::dp_stat_t   stat,
    output logic                       in_ready,
    output tcsfr_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic {
        S_IDLE,
        S_POP
    } state_t;

    state_t state_reg, state_next;
    logic   pop_sel_reg, pop_sel_next;
    logic   accept;

    // Decode and command generation
    always_comb
    begin
        cmd          = '0;
        in_ready     = (state_reg == S_IDLE) && stat.out_free;
        accept       = in_valid && in_ready;
        pop_sel_next = pop_sel_reg;
        if (state_reg == S_POP)
        begin
            cmd.load_pop = 1'b1;
            cmd.sel      = pop_sel_reg;
            cmd.status   = tcsfr_pkg::ST_OK;
        end
        else if (accept)
        begin
            unique case (op)
                tcsfr_pkg::OP_PUT:
                begin
                    cmd.load_now = 1'b1;
                    if (stat.match_a)
                    begin
                        if (stat.full_a)
                        begin
                            cmd.status = tcsfr_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_a   = 1'b1;
                            cmd.adv_seq  = 1'b1;
                            cmd.give_seq = 1'b1;
                        end
                    end
                    else if (stat.match_b)
                    begin
                        cmd.sel = 1'b1;
                        if (stat.full_b)
                        begin
                            cmd.status = tcsfr_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push_b   = 1'b1;
                            cmd.adv_seq  = 1'b1;
                            cmd.give_seq = 1'b1;
                        end
                    end
                    else
                    begin
                        // unmatched part still uses up a number
                        cmd.status   = tcsfr_pkg::ST_DROP;
                        cmd.adv_seq  = 1'b1;
                        cmd.give_seq = 1'b1;
                    end
                end
                tcsfr_pkg::OP_END:
                begin
                    cmd.load_now = 1'b1;
                    if (stat.full_a)
                    begin
                        cmd.status = tcsfr_pkg::ST_FULL;
                    end
                    else if (stat.full_b)
                    begin
                        cmd.status = tcsfr_pkg::ST_FULL;
                        cmd.sel    = 1'b1;
                    end
                    else
                    begin
                        cmd.push_a   = 1'b1;
                        cmd.push_b   = 1'b1;
                        cmd.mark_end = 1'b1;
                        cmd.adv_seq  = 1'b1;
                        cmd.give_seq = 1'b1;
                    end
                end
                tcsfr_pkg::OP_GET_A:
                begin
                    if (stat.empty_a)
                    begin
                        cmd.load_now = 1'b1;
                        cmd.status   = tcsfr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_a     = 1'b1;
                        pop_sel_next = 1'b0;
                    end
                end
                tcsfr_pkg::OP_GET_B:
                begin
                    cmd.sel = 1'b1;
                    if (stat.empty_b)
                    begin
                        cmd.load_now = 1'b1;
                        cmd.status   = tcsfr_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_b     = 1'b1;
                        pop_sel_next = 1'b1;
                    end
                end
                default:
                begin
                    cmd = '0;
                end
            endcase
        end
        state_next = (cmd.rd_a || cmd.rd_b) ? S_POP : S_IDLE;
    end

    // State and pop select registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pop_sel_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pop_sel_reg <= pop_sel_next;
        end
    end

    // A stored push always takes a sequence number and reports it
    `TCSFR_ASSERT(a_push_adv, (cmd.push_a || cmd.push_b) |-> (cmd.adv_seq && cmd.give_seq), "push without sequence advance")
    // The RAM read issued in idle is always followed by its load
    `TCSFR_ASSERT(a_pop_follows, (cmd.rd_a || cmd.rd_b) |=> cmd.load_pop, "pop read not followed by load")

endmodule

`default_nettype wire

// ===== rtl/core/tcsfr_dp.sv =====
// Datapath of the router: config registers, classifier, two ring FIFOs, sequence
// counter and the result register. Depends on tcsfr_pkg, tcsfr_ram and the header.
`default_nettype none
`include "two_class_sequenced_fifo_router_top_defines.svh"

module tcsfr_dp #(
    parameter int DEPTH_A  = tcsfr_pkg::DEPTH_A_DEF,
    parameter int DEPTH_B  = tcsfr_pkg::DEPTH_B_DEF,
    parameter int SEQ_BITS = tcsfr_pkg::SEQ_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [tcsfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [tcsfr_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [tcsfr_pkg::PART_W-1:0]        part_in,
    input  wire tcsfr_pkg::ctrl_cmd_t                cmd,
    output tcsfr_pkg::dp_stat_t                      stat,
    input  wire logic                                out_ready,
    output logic                                     out_valid,
    output tcsfr_pkg::status_t                       out_status,
    output logic                                     out_sel,
    output logic [tcsfr_pkg::PART_W-1:0]             out_part,
    output logic [tcsfr_pkg::OUT_SEQ_W-1:0]          out_seq,
    output logic                                     out_end
);

    localparam int PW  = tcsfr_pkg::PART_W;
    localparam int EW  = PW + SEQ_BITS + 1;
    localparam int AWA = $clog2(DEPTH_A);
    localparam int AWB = $clog2(DEPTH_B);
    localparam int CWA = $clog2(DEPTH_A + 1);
    localparam int CWB = $clog2(DEPTH_B + 1);

    logic [tcsfr_pkg::CFG_W-1:0] a_low_reg, a_high_reg, b_low_reg, b_high_reg;
    logic [AWA-1:0] wr_a_reg, rd_a_reg;
    logic [AWB-1:0] wr_b_reg, rd_b_reg;
    logic [CWA-1:0] count_a_reg;
    logic [CWB-1:0] count_b_reg;
    logic [SEQ_BITS-1:0] seq_reg;
    logic valid_reg;
    tcsfr_pkg::status_t status_reg;
    logic sel_reg, end_reg;
    logic [PW-1:0] part_reg;
    logic [tcsfr_pkg::OUT_SEQ_W-1:0] seq_out_reg;

    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata_a, rdata_b, rdata;
    logic          pop_end;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_low_reg  <= tcsfr_pkg::A_LOW_RST;
            a_high_reg <= tcsfr_pkg::A_HIGH_RST;
            b_low_reg  <= tcsfr_pkg::B_LOW_RST;
            b_high_reg <= tcsfr_pkg::B_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcsfr_pkg::REG_A_LOW:  a_low_reg  <= cfg_data;
                tcsfr_pkg::REG_A_HIGH: a_high_reg <= cfg_data;
                tcsfr_pkg::REG_B_LOW:  b_low_reg  <= cfg_data;
                tcsfr_pkg::REG_B_HIGH: b_high_reg <= cfg_data;
                default:               a_low_reg  <= a_low_reg;
            endcase
        end
    end

    // Classifier and queue status
    always_comb
    begin
        stat.match_a  = (part_in >= a_low_reg) && (part_in <= a_high_reg);
        stat.match_b  = (part_in >= b_low_reg) && (part_in <= b_high_reg);
        stat.full_a   = (count_a_reg == CWA'(DEPTH_A));
        stat.full_b   = (count_b_reg == CWB'(DEPTH_B));
        stat.empty_a  = (count_a_reg == '0);
        stat.empty_b  = (count_b_reg == '0);
        stat.out_free = !valid_reg || out_ready;
    end

    // Entry: end flag, sequence, part (part in low bits)
    assign wdata = cmd.mark_end ? {1'b1, seq_reg, {PW{1'b0}}} : {1'b0, seq_reg, part_in};

    // Queue pointers, counts and sequence counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_a_reg    <= '0;
            rd_a_reg    <= '0;
            count_a_reg <= '0;
            wr_b_reg    <= '0;
            rd_b_reg    <= '0;
            count_b_reg <= '0;
            seq_reg     <= SEQ_BITS'(1);
        end
        else
        begin
            if (cmd.push_a)
            begin
                wr_a_reg    <= (wr_a_reg == AWA'(DEPTH_A - 1)) ? '0 : wr_a_reg + 1'b1;
                count_a_reg <= count_a_reg + 1'b1;
            end
            else if (cmd.rd_a)
            begin
                rd_a_reg    <= (rd_a_reg == AWA'(DEPTH_A - 1)) ? '0 : rd_a_reg + 1'b1;
                count_a_reg <= count_a_reg - 1'b1;
            end
            if (cmd.push_b)
            begin
                wr_b_reg    <= (wr_b_reg == AWB'(DEPTH_B - 1)) ? '0 : wr_b_reg + 1'b1;
                count_b_reg <= count_b_reg + 1'b1;
            end
            else if (cmd.rd_b)
            begin
                rd_b_reg    <= (rd_b_reg == AWB'(DEPTH_B - 1)) ? '0 : rd_b_reg + 1'b1;
                count_b_reg <= count_b_reg - 1'b1;
            end
            if (cmd.adv_seq)
            begin
                seq_reg <= seq_reg + 1'b1;
            end
        end
    end

    tcsfr_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH_A)
    ) u_ram_a (
        .clk   (clk),
        .we    (cmd.push_a),
        .waddr (wr_a_reg),
        .wdata (wdata),
        .re    (cmd.rd_a),
        .raddr (rd_a_reg),
        .rdata (rdata_a)
    );

    tcsfr_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH_B)
    ) u_ram_b (
        .clk   (clk),
        .we    (cmd.push_b),
        .waddr (wr_b_reg),
        .wdata (wdata),
        .re    (cmd.rd_b),
        .raddr (rd_b_reg),
        .rdata (rdata_b)
    );

    assign rdata   = cmd.sel ? rdata_b : rdata_a;
    assign pop_end = rdata[EW-1];

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.load_now || cmd.load_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_pop)
        begin
            status_reg  <= cmd.status;
            sel_reg     <= cmd.sel;
            part_reg    <= pop_end ? '0 : rdata[PW-1:0];
            seq_out_reg <= tcsfr_pkg::OUT_SEQ_W'(rdata[PW+SEQ_BITS-1:PW]);
            end_reg     <= pop_end;
        end
        else if (cmd.load_now)
        begin
            status_reg  <= cmd.status;
            sel_reg     <= cmd.sel;
            part_reg    <= '0;
            seq_out_reg <= cmd.give_seq ? tcsfr_pkg::OUT_SEQ_W'(seq_reg) : '0;
            end_reg     <= 1'b0;
        end
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_sel    = sel_reg;
    assign out_part   = part_reg;
    assign out_seq    = seq_out_reg;
    assign out_end    = end_reg;

    `TCSFR_ASSERT(a_cnt_a, count_a_reg <= CWA'(DEPTH_A), "queue A count above depth")
    `TCSFR_ASSERT(a_cnt_b, count_b_reg <= CWB'(DEPTH_B), "queue B count above depth")
    `TCSFR_ASSERT(a_no_overwrite, (valid_reg && !out_ready) |-> !(cmd.load_now || cmd.load_pop), "result overwritten before taken")
    `TCSFR_ASSERT(a_pop_nonempty, cmd.rd_a |-> !stat.empty_a, "pop from empty queue A")

endmodule

`default_nettype wire

// ===== rtl/core/two_class_sequenced_fifo_router_top.sv =====
// Two-class sequenced FIFO router. Each input item is one operation: a put classifies
// the part against two configurable inclusive ranges (A tested first) and, if it matches
// and that queue has room, stores it with the running sequence number in ring FIFO A or B;
// an end pushes an end marker into both, and a get pops the oldest entry of one queue.
// Every item gives exactly one result item. A get that pops reads through the registered
// read port of the queue RAM before loading the result; other items load it directly. A
// result waits in an output register, and the next item is taken in the same cycle the
// waiting result is taken. Queue storage starts unwritten: only popped entries are ever
// read, so no clearing pass is run. Depends on tcsfr_pkg, tcsfr_ctrl, tcsfr_dp, tcsfr_ram.
`default_nettype none

module two_class_sequenced_fifo_router_top #(
    parameter int DEPTH_A  = tcsfr_pkg::DEPTH_A_DEF,
    parameter int DEPTH_B  = tcsfr_pkg::DEPTH_B_DEF,
    parameter int SEQ_BITS = tcsfr_pkg::SEQ_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] part_value
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] part_out, [23:8] seq_out
    output logic [3:0]       m_tuser,   // [2:0] status, [3] queue_sel
    output logic             m_tlast    // end_out
);

    tcsfr_pkg::ctrl_cmd_t cmd;
    tcsfr_pkg::dp_stat_t  stat;
    tcsfr_pkg::status_t   out_status;
    logic                 out_sel;
    logic [7:0]           out_part;
    logic [15:0]          out_seq;

    tcsfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (tcsfr_pkg::op_t'(s_tuser)),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    tcsfr_dp #(
        .DEPTH_A  (DEPTH_A),
        .DEPTH_B  (DEPTH_B),
        .SEQ_BITS (SEQ_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .part_in    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_sel    (out_sel),
        .out_part   (out_part),
        .out_seq    (out_seq),
        .out_end    (m_tlast)
    );

    assign m_tdata = {out_seq, out_part};
    assign m_tuser = {out_sel, out_status};

endmodule

`default_nettype wire

// ===== dv/two_class_sequenced_fifo_router_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for two_class_sequenced_fifo_router_top: streams put, end and get
// items through the router under random stalls and checks every result item in order.
// Depends on tcsfr_pkg and the router RTL; the expected results come from its own queue model.

module two_class_sequenced_fifo_router_top_tb;
    import tcsfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int BLOCK_ITEMS    = 165;
    localparam int MAX_REPORTS    = 10;

    // Routing model: two FIFOs, the sequence counter and the class ranges
    class router_scoreboard;
        typedef struct packed {
            logic [PART_W-1:0]    part;
            logic [OUT_SEQ_W-1:0] seq;
            logic                 is_end;
        } slot_t;

        typedef struct packed {
            status_t              status;
            logic                 sel;
            logic [PART_W-1:0]    part;
            logic [OUT_SEQ_W-1:0] seq;
            logic                 is_end;
        } route_result_t;

        slot_t                lane[2][$];
        int                   lane_depth[2];
        logic [CFG_W-1:0]     range_lo[2];
        logic [CFG_W-1:0]     range_hi[2];
        logic [OUT_SEQ_W-1:0] next_seq;
        route_result_t        expected_results[$];
        int                   mismatches;

        function new();
            lane_depth[0] = DEPTH_A_DEF;
            lane_depth[1] = DEPTH_B_DEF;
            range_lo[0]   = A_LOW_RST;
            range_hi[0]   = A_HIGH_RST;
            range_lo[1]   = B_LOW_RST;
            range_hi[1]   = B_HIGH_RST;
            next_seq      = 1;
            mismatches    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_A_LOW:  range_lo[0] = val;
                REG_A_HIGH: range_hi[0] = val;
                REG_B_LOW:  range_lo[1] = val;
                REG_B_HIGH: range_hi[1] = val;
                default:    ;
            endcase
        endfunction

        // Predict the result of one accepted item and queue it
        function void note_op(op_t op, logic [PART_W-1:0] part);
            route_result_t r;
            slot_t         s;
            int            q;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_PUT:
                begin
                    // A is tested first, so it wins on overlap
                    q = -1;
                    if (part >= range_lo[0] && part <= range_hi[0])
                        q = 0;
                    else if (part >= range_lo[1] && part <= range_hi[1])
                        q = 1;
                    if (q < 0)
                    begin
                        // dropped, but the number is still used up
                        r.status = ST_DROP;
                        r.seq    = next_seq;
                        next_seq++;
                    end
                    else
                    begin
                        r.sel = q[0];
                        if (lane[q].size() >= lane_depth[q])
                            r.status = ST_FULL;
                        else
                        begin
                            lane[q].push_back('{part: part, seq: next_seq, is_end: 1'b0});
                            r.seq = next_seq;
                            next_seq++;
                        end
                    end
                end
                OP_END:
                begin
                    if (lane[0].size() >= lane_depth[0])
                        r.status = ST_FULL;
                    else if (lane[1].size() >= lane_depth[1])
                    begin
                        r.status = ST_FULL;
                        r.sel    = 1'b1;
                    end
                    else
                    begin
                        s = '{part: '0, seq: next_seq, is_end: 1'b1};
                        lane[0].push_back(s);
                        lane[1].push_back(s);
                        r.seq = next_seq;
                        next_seq++;
                    end
                end
                default:
                begin
                    q = (op == OP_GET_B) ? 1 : 0;
                    r.sel = q[0];
                    if (lane[q].size() == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        s        = lane[q].pop_front();
                        r.part   = s.is_end ? '0 : s.part;
                        r.seq    = s.seq;
                        r.is_end = s.is_end;
                    end
                end
            endcase
            expected_results.push_back(r);
        endfunction

        // Compare one result item with the oldest prediction
        function void check_result(logic [3:0] user, logic [23:0] data, logic last);
            route_result_t got;
            route_result_t want;
            got.status = status_t'(user[2:0]);
            got.sel    = user[3];
            got.part   = data[7:0];
            got.seq    = data[23:8];
            got.is_end = last;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result item with nothing expected: status %0d seq %0d",
                             $realtime, got.status, got.seq);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.sel !== want.sel || got.part !== want.part ||
                got.seq !== want.seq || got.is_end !== want.is_end)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("%0t: mismatch (expected/actual) status %0d/%0d sel %0d/%0d ",
                           $realtime, want.status, got.status, want.sel, got.sel);
                    $display("part %0d/%0d seq %0d/%0d end %0d/%0d",
                             want.part, got.part, want.seq, got.seq, want.is_end, got.is_end);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_len = 0;

    router_scoreboard scoreboard = new();

    two_class_sequenced_fifo_router_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one item after a random gap, return at the edge it is accepted
    task automatic send_item(input op_t op, input logic [7:0] part);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= part;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait for every predicted result item
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (scoreboard.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all four class bounds; only called while the router is idle
    task automatic write_ranges(input logic [7:0] a_lo, input logic [7:0] a_hi,
                                input logic [7:0] b_lo, input logic [7:0] b_hi);
        logic [CFG_IDX_W-1:0] idx[4];
        logic [CFG_W-1:0]     vals[4];
        idx  = '{REG_A_LOW, REG_A_HIGH, REG_B_LOW, REG_B_HIGH};
        vals = '{a_lo, a_hi, b_lo, b_hi};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            scoreboard.set_register(idx[k], vals[k]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Fill segments lean on puts and ends, drain segments on gets
    function automatic op_t pick_op(bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling)
        begin
            if (r < 55) return OP_PUT;
            if (r < 75) return OP_END;
            if (r < 87) return OP_GET_A;
            return OP_GET_B;
        end
        if (r < 15) return OP_PUT;
        if (r < 20) return OP_END;
        if (r < 60) return OP_GET_A;
        return OP_GET_B;
    endfunction

    // Mostly parts inside one of the live ranges, the rest anywhere
    function automatic logic [7:0] pick_part();
        int r;
        int q;
        r = $urandom_range(0, 99);
        q = r % 2;
        if (r < 60 && scoreboard.range_lo[q] <= scoreboard.range_hi[q])
            return 8'($urandom_range(scoreboard.range_lo[q], scoreboard.range_hi[q]));
        return 8'($urandom_range(0, 255));
    endfunction

    // Result side: random stalls plus one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_len--;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Both handshakes feed the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                scoreboard.note_op(op_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                scoreboard.check_result(m_tuser, m_tdata, m_tlast);
        end
    end

    // Watchdog on cycles with no item moving on either side
    initial
    begin
        int stall;
        stall = 0;
        while (stall < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("two_class_sequenced_fifo_router_top_tb: done, errors");
        $finish;
    end

    initial
    begin
        int left_a;
        int left_b;
        cfg_we    = 1'b0;
        cfg_index = REG_A_LOW;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_PUT;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty gets, range edges, end marker, pops in order
        send_item(OP_GET_A, 8'h00);
        send_item(OP_GET_B, 8'hff);
        send_item(OP_PUT, 8'd0);
        send_item(OP_PUT, 8'd1);
        send_item(OP_PUT, 8'd12);
        send_item(OP_PUT, 8'd13);
        send_item(OP_PUT, 8'd25);
        send_item(OP_PUT, 8'd26);
        send_item(OP_PUT, 8'd255);
        send_item(OP_END, 8'h5a);
        repeat (4) send_item(OP_GET_A, 8'ha5);
        repeat (4) send_item(OP_GET_B, 8'h00);
        wait_drained();

        // Random blocks: two per idling mode, new class ranges each block
        for (int blk = 0; blk < 6; blk++)
        begin
            case (blk / 2)
                0:
                begin
                    tx_idle_pct = 36;
                    rx_idle_pct = 63;
                end
                1:
                begin
                    tx_idle_pct = 63;
                    rx_idle_pct = 36;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (blk)
                0:       write_ranges(8'd10, 8'd100, 8'd50, 8'd200);   // overlap, A wins
                1:       write_ranges(8'd0, 8'd0, 8'd255, 8'd255);
                2:       write_ranges(8'd0, 8'd255, 8'd0, 8'd255);
                3:       write_ranges(8'd200, 8'd100, 8'd0, 8'd255);   // A range empty
                default: write_ranges(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            endcase
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                if (blk == 1 && i == 20)
                    rx_hold_len = HOLD_CYCLES;
                if (blk == 3 && i == 80)
                    wait_drained();
                send_item(pick_op((i % 100) < 60), pick_part());
            end
            wait_drained();
        end

        // Closing run: back to reset ranges, empty both queues, then a short directed tail
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_ranges(A_LOW_RST, A_HIGH_RST, B_LOW_RST, B_HIGH_RST);
        left_a = scoreboard.lane[0].size();
        left_b = scoreboard.lane[1].size();
        repeat (left_a) send_item(OP_GET_A, 8'h00);
        repeat (left_b) send_item(OP_GET_B, 8'h00);
        send_item(OP_PUT, 8'd200);
        send_item(OP_PUT, 8'd5);
        send_item(OP_PUT, 8'd20);
        send_item(OP_END, 8'h00);
        send_item(OP_PUT, 8'd6);
        send_item(OP_PUT, 8'd14);
        repeat (4) send_item(OP_GET_A, 8'h00);
        repeat (4) send_item(OP_GET_B, 8'h00);
        wait_drained();

        repeat (10) @(posedge clk);
        if (scoreboard.mismatches == 0 && scoreboard.expected_results.size() == 0)
            $display("two_class_sequenced_fifo_router_top_tb: done, clean");
        else
            $display("two_class_sequenced_fifo_router_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tcsfr_pkg.sv
rtl/core/tcsfr_ram.sv
rtl/core/tcsfr_ctrl.sv
rtl/core/tcsfr_dp.sv
rtl/core/two_class_sequenced_fifo_router_top.sv
dv/two_class_sequenced_fifo_router_top_tb.sv
